// ===== hdl/ecs_pkg.sv =====
package ecs_pkg;

  // Width of the scaled span and of its square root.
  localparam int SPAN_BITS   = 16;
  localparam int ROOT_BITS   = SPAN_BITS / 2;
  localparam int RADIUS_Y_BITS = 8;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RX2   = 9'b000000010,
    S_OFF2  = 9'b000000100,
    S_RY2   = 9'b000001000,
    S_PROD  = 9'b000010000,
    S_DLOAD = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_ROOT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } ecs_state_t;

endpackage

// ===== hdl/ellipse_column_span.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   center_x, center_y, radius_x, radius_y, column_x
// out      output     out_valid / out_stall plot_x, row_upper, row_lower
//
// A column request passes from acceptance to a loaded result through four multiplier
// passes, a load state, 16 divider steps, eight square root steps with a wait for their
// done flag, and an output load state; a new request is taken only from idle.
// Outside columns return to idle from S_RY2; a zero horizontal radius skips the divider.
// Reset clears the sequencer, out_valid and the root busy and done flags only.
// The result register holds while out_stall is high; a new request may be taken meanwhile.
module ellipse_column_span_core #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      center_x,
  input  logic signed [COORD_BITS-1:0]      center_y,
  input  logic        [RADIUS_BITS-1:0]     radius_x,
  input  logic        [ecs_pkg::RADIUS_Y_BITS-1:0] radius_y,
  input  logic signed [COORD_BITS-1:0]      column_x,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      plot_x,
  output logic signed [COORD_BITS:0]        row_upper,
  output logic signed [COORD_BITS:0]        row_lower
);
  import ecs_pkg::*;

  localparam int OFF_W = COORD_BITS + 1;
  localparam int IN_W  = 2 * RADIUS_BITS;
  localparam int MA    = (OFF_W > SPAN_BITS) ? OFF_W : SPAN_BITS;
  localparam int MB    = (OFF_W > IN_W) ? OFF_W : IN_W;
  localparam int PW    = MA + MB;
  localparam int DV_W  = SPAN_BITS + IN_W;
  localparam int CNT_W = $clog2(SPAN_BITS);

  ecs_state_t state, state_next;

  logic signed [COORD_BITS-1:0]  cy;
  logic signed [COORD_BITS-1:0]  col;
  logic [RADIUS_BITS-1:0]        rx;
  logic [RADIUS_Y_BITS-1:0]      ry;
  logic [OFF_W-1:0]              mag;
  logic [IN_W-1:0]               rx2;
  logic [IN_W-1:0]               slack;
  logic [PW-1:0]                 prod;
  logic [IN_W-1:0]               rem;
  logic [SPAN_BITS-1:0]          dq;
  logic [CNT_W-1:0]              cnt;

  logic signed [OFF_W-1:0]       offset;
  logic [MA-1:0]                 op_a;
  logic [MB-1:0]                 op_b;
  logic [IN_W:0]                 trial;
  logic                          fits;
  logic [IN_W-1:0]               rem_next;
  logic [SPAN_BITS-1:0]          dq_next;
  logic                          last_div;
  logic [ROOT_BITS-1:0]          root;
  logic                          root_start;
  logic                          root_done;

  assign in_stall = (state != S_IDLE);
  assign offset   = OFF_W'(column_x) - OFF_W'(center_x);
  assign last_div = (cnt == CNT_W'(SPAN_BITS - 1));

  // Operand select for the one shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_RX2: begin
        op_a = MA'(rx);
        op_b = MB'(rx);
      end
      S_OFF2: begin
        op_a = MA'(mag);
        op_b = MB'(mag);
      end
      S_RY2: begin
        op_a = MA'(ry);
        op_b = MB'(ry);
      end
      S_PROD: begin
        op_a = MA'(prod[SPAN_BITS-1:0]);
        op_b = MB'(slack);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Restoring division step; the quotient never exceeds SPAN_BITS bits because
  // slack is at most rx2.
  always_comb begin
    trial    = {rem, dq[SPAN_BITS-1]};
    fits     = (trial >= {1'b0, rx2});
    rem_next = fits ? IN_W'(trial - {1'b0, rx2}) : trial[IN_W-1:0];
    dq_next  = dq;
    if (state == S_DLOAD) begin
      dq_next = (rx2 == '0) ? '0 : prod[SPAN_BITS-1:0];
    end else if (state == S_DIV) begin
      dq_next = {dq[SPAN_BITS-2:0], fits};
    end
  end

  assign root_start = ((state == S_DLOAD) && (rx2 == '0)) || ((state == S_DIV) && last_div);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_RX2;
      S_RX2:   state_next = S_OFF2;
      S_OFF2:  state_next = S_RY2;
      S_RY2:   state_next = (prod > PW'(rx2)) ? S_IDLE : S_PROD;
      S_PROD:  state_next = S_DLOAD;
      S_DLOAD: state_next = (rx2 == '0) ? S_ROOT : S_DIV;
      S_DIV:   if (last_div) state_next = S_ROOT;
      S_ROOT:  if (root_done) state_next = S_DONE;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cy  <= center_y;
      col <= column_x;
      rx  <= radius_x;
      ry  <= radius_y;
      mag <= offset[OFF_W-1] ? OFF_W'(-offset) : OFF_W'(offset);
    end
    if (state == S_RX2 || state == S_OFF2 || state == S_RY2 || state == S_PROD) begin
      prod <= PW'(op_a) * PW'(op_b);
    end
    if (state == S_OFF2) begin
      rx2 <= prod[IN_W-1:0];
    end
    if (state == S_RY2) begin
      slack <= rx2 - prod[IN_W-1:0];
    end
    if (state == S_DLOAD) begin
      rem <= prod[DV_W-1:SPAN_BITS];
      cnt <= '0;
    end else if (state == S_DIV) begin
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
    end
    dq <= dq_next;
    // The root unit holds its result until the next request starts it again.
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      plot_x    <= col;
      row_upper <= {cy[COORD_BITS-1], cy} - (COORD_BITS+1)'(root);
      row_lower <= {cy[COORD_BITS-1], cy} + (COORD_BITS+1)'(root);
    end
  end

  ecs_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .span  (dq_next),
    .done  (root_done),
    .root  (root)
  );

endmodule

// ===== hdl/ecs_root.sv =====
module ecs_root (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ecs_pkg::SPAN_BITS-1:0] span,
  output logic                         done,
  output logic [ecs_pkg::ROOT_BITS-1:0] root
);
  import ecs_pkg::*;

  localparam int ITER  = SPAN_BITS / 2;
  localparam int CNT_W = $clog2(ITER);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [SPAN_BITS-1:0] n;
  logic [SPAN_BITS-1:0] rt;
  logic [SPAN_BITS-1:0] bt;

  logic [SPAN_BITS:0]   sum;
  logic                 take;
  logic [SPAN_BITS-1:0] n_next;
  logic [SPAN_BITS-1:0] rt_next;

  // One digit of the bitwise square root per cycle while busy.
  always_comb begin
    sum     = {1'b0, rt} + {1'b0, bt};
    take    = ({1'b0, n} >= sum);
    n_next  = take ? (n - sum[SPAN_BITS-1:0]) : n;
    rt_next = take ? ((rt >> 1) + bt) : (rt >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= span;
      rt  <= '0;
      bt  <= SPAN_BITS'(1) << (SPAN_BITS - 2);
      cnt <= '0;
    end else if (busy) begin
      n   <= n_next;
      rt  <= rt_next;
      bt  <= bt >> 2;
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign root = rt[ROOT_BITS-1:0];

endmodule

// ===== sim/ellipse_span_checker.sv =====
module ellipse_span_checker #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 9
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         center_x,
  input  logic signed [COORD_BITS-1:0]         center_y,
  input  logic        [RADIUS_BITS-1:0]        radius_x,
  input  logic        [ecs_pkg::RADIUS_Y_BITS-1:0] radius_y,
  input  logic signed [COORD_BITS-1:0]         column_x,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [COORD_BITS-1:0]         plot_x,
  input  logic signed [COORD_BITS:0]           row_upper,
  input  logic signed [COORD_BITS:0]           row_lower,
  output int                                   errors,
  output int                                   outstanding
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] plot_x;
    logic signed [COORD_BITS:0]   row_upper;
    logic signed [COORD_BITS:0]   row_lower;
  } outline_t;

  outline_t rows_due[$];

  function automatic longint floor_root(longint span);
    longint root;
    longint trial;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= span) root = trial;
    end
    return root;
  endfunction

  // Returns 0 when the column lies outside the ellipse and no transaction follows.
  function automatic bit predict_outline(
    input  logic signed [COORD_BITS-1:0]         cx,
    input  logic signed [COORD_BITS-1:0]         cy,
    input  logic        [RADIUS_BITS-1:0]        rx,
    input  logic        [ecs_pkg::RADIUS_Y_BITS-1:0] ry,
    input  logic signed [COORD_BITS-1:0]         col,
    output outline_t                             pts
  );
    longint off;
    longint rx2;
    longint slack;
    longint span;
    longint root;
    longint upper;
    longint lower;
    off    = longint'(col) - longint'(cx);
    rx2    = longint'(rx) * longint'(rx);
    slack  = rx2 - off * off;
    pts    = '0;
    if (slack < 0) return 1'b0;
    // A zero horizontal radius only reaches here at the center column; span is then zero.
    span  = (rx2 == 0) ? 0 : (longint'(ry) * longint'(ry) * slack) / rx2;
    root  = floor_root(span);
    upper = longint'(cy) - root;
    lower = longint'(cy) + root;
    pts.plot_x    = col;
    pts.row_upper = upper[COORD_BITS:0];
    pts.row_lower = lower[COORD_BITS:0];
    return 1'b1;
  endfunction

  function automatic void report(string what, outline_t want);
    if (errors < 10)
      $display("%0t: %s: expected x=%0d upper=%0d lower=%0d, got x=%0d upper=%0d lower=%0d",
               $time, what, want.plot_x, want.row_upper, want.row_lower,
               plot_x, row_upper, row_lower);
    errors++;
  endfunction

  always @(posedge clk) begin : watch
    outline_t pts;
    outline_t want;
    if (rst) begin
      rows_due.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_outline(center_x, center_y, radius_x, radius_y, column_x, pts))
          rows_due.push_back(pts);
      end
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          report("result with nothing pending", '0);
        end else begin
          want = rows_due.pop_front();
          if (plot_x !== want.plot_x || row_upper !== want.row_upper ||
              row_lower !== want.row_lower)
            report("outline mismatch", want);
        end
      end
      outstanding <= rows_due.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 9;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]         center_x;
    logic signed [COORD_BITS-1:0]         center_y;
    logic        [RADIUS_BITS-1:0]        radius_x;
    logic        [ecs_pkg::RADIUS_Y_BITS-1:0] radius_y;
    logic signed [COORD_BITS-1:0]         column_x;
  } column_req_t;

  typedef enum int {RX_FREE, RX_BLOCKED, RX_COIN, RX_TOGGLE} stall_mode_t;

  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 in_valid  = 1'b0;
  logic                                 out_stall = 1'b0;
  logic signed [COORD_BITS-1:0]         center_x  = '0;
  logic signed [COORD_BITS-1:0]         center_y  = '0;
  logic        [RADIUS_BITS-1:0]        radius_x  = '0;
  logic        [ecs_pkg::RADIUS_Y_BITS-1:0] radius_y = '0;
  logic signed [COORD_BITS-1:0]         column_x  = '0;
  logic                                 in_stall;
  logic                                 out_valid;
  logic signed [COORD_BITS-1:0]         plot_x;
  logic signed [COORD_BITS:0]           row_upper;
  logic signed [COORD_BITS:0]           row_lower;
  int                                   errors;
  int                                   outstanding;
  int                                   cycles = 0;
  bit                                   hold_request = 1'b0;
  bit                                   steady = 1'b0;

  always #5 clk = ~clk;

  ellipse_column_span_core #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .center_x (center_x),
    .center_y (center_y),
    .radius_x (radius_x),
    .radius_y (radius_y),
    .column_x (column_x),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plot_x   (plot_x),
    .row_upper(row_upper),
    .row_lower(row_lower)
  );

  ellipse_span_checker #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius_x   (radius_x),
    .radius_y   (radius_y),
    .column_x   (column_x),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plot_x     (plot_x),
    .row_upper  (row_upper),
    .row_lower  (row_lower),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic column_req_t make_req(int cx, int cy, int rx, int ry, int col);
    column_req_t r;
    r.center_x = cx[COORD_BITS-1:0];
    r.center_y = cy[COORD_BITS-1:0];
    r.radius_x = rx[RADIUS_BITS-1:0];
    r.radius_y = ry[ecs_pkg::RADIUS_Y_BITS-1:0];
    r.column_x = col[COORD_BITS-1:0];
    return r;
  endfunction

  // Most requests hit a column inside the ellipse; the rest sit on or just past
  // its edge, or are unconstrained noise.
  function automatic column_req_t random_req();
    int pick;
    int rx;
    int off;
    int cx;
    pick = $urandom_range(0, 99);
    if (pick < 20)
      return make_req($urandom, $urandom, $urandom, $urandom, $urandom);
    rx  = (pick < 22) ? 0 : int'($urandom_range(1, 511));
    off = int'($urandom_range(0, 2 * rx)) - rx;
    if (pick >= 22 && pick < 30) begin
      off = rx + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) off = -off;
    end
    cx = int'($urandom_range(0, 4095 - 2 * rx)) - 2048 + rx;
    return make_req(cx, int'($urandom_range(0, 4095)) - 2048, rx,
                    $urandom_range(0, 255), cx + off);
  endfunction

  task automatic offer(column_req_t r);
    in_valid <= 1'b1;
    center_x <= r.center_x;
    center_y <= r.center_y;
    radius_x <= r.radius_x;
    radius_y <= r.radius_y;
    column_x <= r.column_x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          run;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = steady ? RX_FREE : stall_mode_t'($urandom_range(0, 3));
        run  = $urandom_range(1, (mode == RX_BLOCKED) ? 6 : 16);
        repeat (run) begin
          case (mode)
            RX_FREE:    out_stall <= 1'b0;
            RX_BLOCKED: out_stall <= 1'b1;
            RX_COIN:    out_stall <= 1'($urandom_range(0, 1));
            default:    out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    column_req_t directed[$];
    int          burst_left;
    int          gap;
    int          total;
    int          first_random;
    directed.push_back(make_req(0, 0, 1, 0, 0));
    directed.push_back(make_req(0, 0, 511, 255, 0));
    directed.push_back(make_req(0, 5, 511, 181, 511));
    directed.push_back(make_req(0, 5, 511, 181, 512));
    directed.push_back(make_req(0, -5, 511, 181, -511));
    // Zero horizontal radius: only the center column yields a transaction.
    directed.push_back(make_req(100, -100, 0, 50, 100));
    directed.push_back(make_req(100, -100, 0, 50, 101));
    directed.push_back(make_req(1, 1, 0, 0, 1));
    // Far columns: the first two offsets span the whole coordinate range.
    directed.push_back(make_req(-2048, 0, 511, 181, 2047));
    directed.push_back(make_req(2047, 0, 511, 181, -2048));
    directed.push_back(make_req(-2048, -2048, 511, 255, -2048));
    directed.push_back(make_req(2047, 2047, 511, 255, 2047));
    directed.push_back(make_req(2047, -1, 7, 200, 2042));
    directed.push_back(make_req(-300, 40, 300, 0, -200));
    directed.push_back(make_req(0, 0, 511, 255, 300));
    directed.push_back(make_req(-7, 3, 1, 255, -6));
    directed.push_back(make_req(-2048, 1000, 511, 255, -1537));
    directed.push_back(make_req(-1, -1, 255, 128, -1));

    first_random = directed.size();
    total        = first_random + RANDOM_ITEMS;
    burst_left   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < total; n++) begin
      // Let the pipeline run dry before continuing.
      if (n == first_random || n == first_random + 1000) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        burst_left = 0;
      end
      if (n == first_random + 400) hold_request = 1'b1;
      steady = (n >= first_random + 1300 && n < first_random + 1500);
      if (burst_left == 0) begin
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      offer((n < first_random) ? directed[n] : random_req());
      burst_left--;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ecs_pkg.sv
hdl/ecs_root.sv
hdl/ellipse_column_span.sv
sim/ellipse_span_checker.sv
sim/tb_top.sv
